### src/dfs_pkg.sv
package dfs_pkg;

  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic [31:0] SIGN32 = 32'h8000_0000;

  typedef enum logic [1:0] {
    PH_EMPTY = 2'd0,
    PH_READY = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_UPDATE = 2'd2
  } state_t;

  // one task slot as kept in the slot memory
  typedef struct packed {
    logic [15:0] work;
    logic [31:0] deadline;   // two's complement
    logic [15:0] orig;
    logic [31:0] arrival;
    logic [31:0] wait_tm;
    logic        has_run;
  } slot_rec_t;

  typedef struct packed {
    logic        feasible;
    logic        better;
    logic [31:0] dl_next;
  } eval_t;

endpackage

### src/dfs_slot_eval.sv
module dfs_slot_eval
  import dfs_pkg::*;
(
  input  slot_rec_t   rec,
  input  logic        ready,
  input  logic        best_vld,
  input  logic [31:0] best_d,
  output eval_t       ev
);

  logic can_meet;

  // feasible: deadline non-negative and not below remaining work
  assign can_meet = ready && !rec.deadline[31] && (rec.deadline >= {16'd0, rec.work});

  always_comb begin
    ev.feasible = can_meet;
    // strict compare keeps the lowest slot on a tie
    ev.better   = can_meet && (!best_vld || (rec.deadline < best_d));
    ev.dl_next  = (rec.deadline == SIGN32) ? rec.deadline : rec.deadline - 32'd1;
  end

endmodule

### src/deadline_feasible_scheduler_top.sv
// Earliest-deadline scheduler over SLOTS task slots, one tick of work per tick item.
// Input: an item is taken at a rising edge with start high and busy low.
//   req_type arrival loads slot with service_time and rel_deadline, stamped with
//   the current time, and gives no result. An arrival to a slot at or beyond
//   SLOTS is dropped.
//   req_type tick scans every slot, runs at most one task, and reports.
// Output: done is high for exactly one cycle with the tick's result on
//   tick_time, ran_valid, ran_slot, finished, turnaround, first_wait, deadline_met.
//   The receiver cannot stall; the result is simply presented for that cycle.
// Sequence: a tick keeps busy high while it scans the slots and updates the chosen
//   one; done is high in the first cycle with busy low, which is also a cycle in
//   which the next item may start. The scan reads one slot per cycle from the slot
//   memory and writes each ready slot back, through a single compare unit; then
//   the chosen slot is updated.
// Reset: all slots empty, time zero, block idle. The slot memory needs no
//   clearing since only slots marked ready by an arrival are ever used.
module deadline_feasible_scheduler_top
  import dfs_pkg::*;
#(
  parameter int SLOTS = 16
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [3:0]  slot,
  input  logic [15:0] service_time,
  input  logic [15:0] rel_deadline,
  output logic        done,
  output logic [31:0] tick_time,
  output logic        ran_valid,
  output logic [3:0]  ran_slot,
  output logic        finished,
  output logic [31:0] turnaround,
  output logic [31:0] first_wait,
  output logic        deadline_met
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  state_t state, state_next;

  logic [31:0]   now;
  phase_t        phase [SLOTS];
  slot_rec_t     mem [SLOTS];
  slot_rec_t     rdata;

  logic [CW-1:0] cnt;
  logic          eval_vld;
  logic [IW-1:0] eval_idx;

  logic          best_vld;
  logic [IW-1:0] best_idx;
  logic [31:0]   best_d;
  slot_rec_t     best_rec;
  logic          fb_vld;
  logic [IW-1:0] fb_idx;
  slot_rec_t     fb_rec;

  logic          accept;
  logic          arrive_ok;
  logic [IW-1:0] arrive_idx;
  logic          rd_en;
  logic          eval_ready;
  eval_t         ev;
  slot_rec_t     scan_rec;

  logic          pick_vld;
  logic [IW-1:0] pick_idx;
  slot_rec_t     pick_rec;
  logic [15:0]   work_dec;
  logic          fin;
  logic [31:0]   wait_new;
  logic [31:0]   turn;
  logic          met;
  slot_rec_t     upd_rec;

  logic          we;
  logic [IW-1:0] waddr;
  slot_rec_t     wdata;

  assign accept     = start && !busy;
  assign arrive_ok  = accept && (req_type == REQ_ARRIVE) && (32'(slot) < SLOTS);
  assign arrive_idx = IW'(slot);

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept && req_type == REQ_TICK) state_next = ST_SCAN;
      ST_SCAN:   if (cnt == CW'(SLOTS)) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    rd_en = 1'b0;
    unique case (state)
      ST_IDLE:   busy = 1'b0;
      ST_SCAN:   rd_en = (cnt < CW'(SLOTS));
      ST_UPDATE: busy = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  // ---------------- slot evaluation ----------------
  assign eval_ready = eval_vld && (phase[eval_idx] == PH_READY);

  dfs_slot_eval u_eval (
    .rec      (rdata),
    .ready    (eval_ready),
    .best_vld (best_vld),
    .best_d   (best_d),
    .ev       (ev)
  );

  // deadlines of all ready slots drop during the scan; selection uses the old value
  always_comb begin
    scan_rec          = rdata;
    scan_rec.deadline = ev.dl_next;
  end

  // ---------------- chosen task update ----------------
  assign pick_vld = best_vld || fb_vld;
  assign pick_idx = best_vld ? best_idx : fb_idx;
  assign pick_rec = best_vld ? best_rec : fb_rec;

  always_comb begin
    work_dec = (pick_rec.work == 16'd0) ? 16'd0 : pick_rec.work - 16'd1;
    fin      = pick_vld && (work_dec == 16'd0);
    wait_new = pick_rec.has_run ? pick_rec.wait_tm : now - pick_rec.arrival;
    turn     = now + 32'd1 - pick_rec.arrival;
    met      = (turn <= {16'd0, pick_rec.orig});
    upd_rec          = pick_rec;
    upd_rec.work     = work_dec;
    upd_rec.wait_tm  = wait_new;
    upd_rec.has_run  = 1'b1;
  end

  // ---------------- memory write select ----------------
  always_comb begin
    we    = 1'b0;
    waddr = eval_idx;
    wdata = scan_rec;
    priority if (arrive_ok) begin
      we            = 1'b1;
      waddr         = arrive_idx;
      wdata.work    = service_time;
      wdata.deadline = {16'd0, rel_deadline};
      wdata.orig    = rel_deadline;
      wdata.arrival = now;
      wdata.wait_tm = 32'd0;
      wdata.has_run = 1'b0;
    end else if (state == ST_SCAN && eval_ready) begin
      we = 1'b1;
    end else if (state == ST_UPDATE && pick_vld) begin
      we    = 1'b1;
      waddr = pick_idx;
      wdata = upd_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[cnt[IW-1:0]];
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      now      <= 32'd0;
      cnt      <= '0;
      eval_vld <= 1'b0;
      best_vld <= 1'b0;
      fb_vld   <= 1'b0;
      done     <= 1'b0;
      for (int i = 0; i < SLOTS; i++) phase[i] <= PH_EMPTY;
    end else begin
      state    <= state_next;
      eval_vld <= rd_en;
      done     <= (state == ST_UPDATE);
      if (arrive_ok) phase[arrive_idx] <= PH_READY;
      if (state == ST_IDLE) begin
        cnt      <= '0;
        best_vld <= 1'b0;
        fb_vld   <= 1'b0;
      end else if (state == ST_SCAN) begin
        if (rd_en) cnt <= cnt + CW'(1);
        if (eval_ready && !fb_vld) fb_vld <= 1'b1;
        if (ev.better) best_vld <= 1'b1;
      end else if (state == ST_UPDATE) begin
        now <= now + 32'd1;
        if (fin) phase[pick_idx] <= PH_DONE;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (rd_en) eval_idx <= cnt[IW-1:0];
    if (state == ST_SCAN && eval_ready && !fb_vld) begin
      fb_idx <= eval_idx;
      fb_rec <= scan_rec;
    end
    if (state == ST_SCAN && ev.better) begin
      best_idx <= eval_idx;
      best_d   <= rdata.deadline;
      best_rec <= scan_rec;
    end
    if (state == ST_UPDATE) begin
      tick_time    <= now;
      ran_valid    <= pick_vld;
      ran_slot     <= pick_vld ? 4'(pick_idx) : 4'd0;
      finished     <= fin;
      turnaround   <= fin ? turn : 32'd0;
      first_wait   <= fin ? wait_new : 32'd0;
      deadline_met <= fin && met;
    end
  end

  // ---------------- checks ----------------
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_UPDATE))
    else $error("result strobe without an update step");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_tick_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_TICK) |=> (state == ST_SCAN && cnt == '0))
    else $error("tick item did not start a scan");

  a_finish_needs_run: assert property (@(posedge clk) disable iff (rst)
    (done && finished) |-> ran_valid)
    else $error("task finished without running");

  a_quiet_when_unfinished: assert property (@(posedge clk) disable iff (rst)
    (done && !finished) |-> (!deadline_met && turnaround == 32'd0 && first_wait == 32'd0))
    else $error("completion fields set on an unfinished tick");

endmodule
